[sv/ikrl_pkg.sv]
`default_nettype none

package ikrl_pkg;

	localparam logic [2:0] OP_APPEND = 3'd0;
	localparam logic [2:0] OP_RM_IDX = 3'd1;
	localparam logic [2:0] OP_READ   = 3'd2;
	localparam logic [2:0] OP_FIND   = 3'd3;
	localparam logic [2:0] OP_RM_ID  = 3'd4;
	localparam logic [2:0] OP_CLEAR  = 3'd5;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;

	localparam logic [1:0] RD_POS   = 2'd0;
	localparam logic [1:0] RD_ZERO  = 2'd1;
	localparam logic [1:0] RD_NEXT  = 2'd2;
	localparam logic [1:0] RD_NEXT2 = 2'd3;

	localparam logic [2:0] RES_FULL   = 3'd0;
	localparam logic [2:0] RES_NF     = 3'd1;
	localparam logic [2:0] RES_CLEAR  = 3'd2;
	localparam logic [2:0] RES_APPEND = 3'd3;
	localparam logic [2:0] RES_HIT    = 3'd4;

	typedef struct packed {
		logic       load_op;
		logic       rd_en;
		logic [1:0] rd_sel;
		logic       cur_ld_pos;
		logic       cur_ld_zero;
		logic       cur_inc;
		logic       app_wr;
		logic       shift_wr;
		logic       cnt_inc;
		logic       cnt_dec;
		logic       cnt_clr;
		logic       res_ld;
		logic [2:0] res_sel;
		logic       out_ld;
	} cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       full;
		logic       pos_ok;
		logic       cnt_zero;
		logic       next_ok;
		logic       next2_ok;
		logic       id_match;
		logic       out_free;
	} sts_t;

endpackage

`default_nettype wire

[sv/id_keyed_record_list.sv]
// Append, clear, unused opcodes, an index out of range and a find or removal by ID on an
// empty list finish without a memory read; a read or a removal at an index reads that
// entry, and a find or a removal by ID scans from index 0 until the ID matches or the
// list ends. A removal then shifts each later entry down; search and compaction take one
// entry per cycle. The next input beat is taken only after the result reaches the output
// register; commands do not overlap. Reset clears entry count and output valid, not memory.
`default_nettype none

module id_keyed_record_list #(
	parameter int ENTRIES   = 64,
	parameter int TIME_BITS = 48
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// opcode, key_id, record_address, record_time, position
	input  wire logic [127:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// status, entry_index, entry_id, entry_address, entry_time, entry_count
	output logic [127:0]      m_tdata
);

	ikrl_pkg::cmd_t cmd;
	ikrl_pkg::sts_t sts;

	ikrl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ikrl_dp #(
		.ENTRIES   (ENTRIES),
		.TIME_BITS (TIME_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule

`default_nettype wire

[sv/ikrl_ctrl.sv]
`default_nettype none

module ikrl_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           s_tvalid,
	output logic                s_tready,
	input  wire ikrl_pkg::sts_t sts,
	output ikrl_pkg::cmd_t      cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EXEC  = 3'd1;
	localparam logic [2:0] S_LOOK  = 3'd2;
	localparam logic [2:0] S_SCAN  = 3'd3;
	localparam logic [2:0] S_SHIFT = 3'd4;
	localparam logic [2:0] S_FIN   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		cmd = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load_op = 1'b1;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_FIN;
				cmd.res_ld = 1'b1;
				unique case (sts.op)
					ikrl_pkg::OP_APPEND: begin
						if (sts.full) begin
							cmd.res_sel = ikrl_pkg::RES_FULL;
						end else begin
							cmd.app_wr = 1'b1;
							cmd.cnt_inc = 1'b1;
							cmd.res_sel = ikrl_pkg::RES_APPEND;
						end
					end
					ikrl_pkg::OP_CLEAR: begin
						cmd.cnt_clr = 1'b1;
						cmd.res_sel = ikrl_pkg::RES_CLEAR;
					end
					ikrl_pkg::OP_READ, ikrl_pkg::OP_RM_IDX: begin
						if (sts.pos_ok) begin
							cmd.res_ld = 1'b0;
							cmd.rd_en = 1'b1;
							cmd.rd_sel = ikrl_pkg::RD_POS;
							cmd.cur_ld_pos = 1'b1;
							state_d = S_LOOK;
						end else begin
							cmd.res_sel = ikrl_pkg::RES_NF;
						end
					end
					ikrl_pkg::OP_FIND, ikrl_pkg::OP_RM_ID: begin
						if (sts.cnt_zero) begin
							cmd.res_sel = ikrl_pkg::RES_NF;
						end else begin
							cmd.res_ld = 1'b0;
							cmd.rd_en = 1'b1;
							cmd.rd_sel = ikrl_pkg::RD_ZERO;
							cmd.cur_ld_zero = 1'b1;
							state_d = S_SCAN;
						end
					end
					default: begin
						cmd.res_sel = ikrl_pkg::RES_NF;
					end
				endcase
			end
			S_LOOK: begin
				cmd.res_ld = 1'b1;
				cmd.res_sel = ikrl_pkg::RES_HIT;
				if (sts.op == ikrl_pkg::OP_READ) begin
					state_d = S_FIN;
				end else if (sts.next_ok) begin
					cmd.rd_en = 1'b1;
					cmd.rd_sel = ikrl_pkg::RD_NEXT;
					state_d = S_SHIFT;
				end else begin
					cmd.cnt_dec = 1'b1;
					state_d = S_FIN;
				end
			end
			S_SCAN: begin
				if (sts.id_match) begin
					cmd.res_ld = 1'b1;
					cmd.res_sel = ikrl_pkg::RES_HIT;
					if (sts.op == ikrl_pkg::OP_FIND) begin
						state_d = S_FIN;
					end else if (sts.next_ok) begin
						cmd.rd_en = 1'b1;
						cmd.rd_sel = ikrl_pkg::RD_NEXT;
						state_d = S_SHIFT;
					end else begin
						cmd.cnt_dec = 1'b1;
						state_d = S_FIN;
					end
				end else if (sts.next_ok) begin
					cmd.rd_en = 1'b1;
					cmd.rd_sel = ikrl_pkg::RD_NEXT;
					cmd.cur_inc = 1'b1;
				end else begin
					cmd.res_ld = 1'b1;
					cmd.res_sel = ikrl_pkg::RES_NF;
					state_d = S_FIN;
				end
			end
			S_SHIFT: begin
				cmd.shift_wr = 1'b1;
				if (sts.next2_ok) begin
					cmd.rd_en = 1'b1;
					cmd.rd_sel = ikrl_pkg::RD_NEXT2;
					cmd.cur_inc = 1'b1;
				end else begin
					cmd.cnt_dec = 1'b1;
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.out_ld = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

[sv/ikrl_dp.sv]
`default_nettype none

module ikrl_dp #(
	parameter int ENTRIES   = 64,
	parameter int TIME_BITS = 48
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic [127:0]   s_tdata,
	output logic                m_tvalid,
	input  wire logic           m_tready,
	output logic [127:0]        m_tdata,
	input  wire ikrl_pkg::cmd_t cmd,
	output ikrl_pkg::sts_t      sts
);

	localparam int IW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int XW = (CW > 7) ? CW + 1 : 8;
	localparam int TW = (TIME_BITS < 48) ? TIME_BITS : 48;
	localparam int RW = 64 + TW;

	logic [2:0]    op_q;
	logic [31:0]   key_q;
	logic [31:0]   addr_q;
	logic [TW-1:0] time_q;
	logic [5:0]    pos_q;
	logic [IW-1:0] cur_q;
	logic [CW-1:0] count_q;
	logic [RW-1:0] mem [ENTRIES];
	logic [RW-1:0] rd_q;

	logic [1:0]    res_status_q;
	logic [5:0]    res_index_q;
	logic [RW-1:0] res_rec_q;

	logic          m_tvalid_q;
	logic [1:0]    out_status_q;
	logic [5:0]    out_index_q;
	logic [RW-1:0] out_rec_q;
	logic [6:0]    out_count_q;

	logic [XW-1:0] cur_x;
	logic [XW-1:0] cnt_x;
	logic [XW-1:0] pos_x;
	logic [XW-1:0] next_x;
	logic [XW-1:0] next2_x;
	logic [IW-1:0] rd_addr;
	logic [IW-1:0] wr_addr;
	logic [RW-1:0] wr_data;
	logic [RW-1:0] new_rec;
	logic          wr_en;

	assign cur_x   = XW'(cur_q);
	assign cnt_x   = XW'(count_q);
	assign pos_x   = XW'(pos_q);
	assign next_x  = cur_x + XW'(1);
	assign next2_x = cur_x + XW'(2);
	assign new_rec = {key_q, addr_q, time_q};

	assign sts.op       = op_q;
	assign sts.full     = (count_q == CW'(ENTRIES));
	assign sts.pos_ok   = (pos_x < cnt_x);
	assign sts.cnt_zero = (count_q == '0);
	assign sts.next_ok  = (next_x < cnt_x);
	assign sts.next2_ok = (next2_x < cnt_x);
	assign sts.id_match = (rd_q[RW-1 -: 32] == key_q);
	assign sts.out_free = !m_tvalid_q || m_tready;

	always_comb begin
		unique case (cmd.rd_sel)
			ikrl_pkg::RD_POS:   rd_addr = pos_x[IW-1:0];
			ikrl_pkg::RD_ZERO:  rd_addr = '0;
			ikrl_pkg::RD_NEXT:  rd_addr = next_x[IW-1:0];
			ikrl_pkg::RD_NEXT2: rd_addr = next2_x[IW-1:0];
			default:            rd_addr = '0;
		endcase
	end

	assign wr_en   = cmd.app_wr || cmd.shift_wr;
	assign wr_addr = cmd.app_wr ? cnt_x[IW-1:0] : cur_q;
	assign wr_data = cmd.app_wr ? new_rec : rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (cmd.rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_op) begin
			op_q   <= s_tdata[2:0];
			key_q  <= s_tdata[34:3];
			addr_q <= s_tdata[66:35];
			time_q <= s_tdata[67 +: TW];
			pos_q  <= s_tdata[120:115];
		end
		if (cmd.cur_ld_pos) begin
			cur_q <= pos_x[IW-1:0];
		end else if (cmd.cur_ld_zero) begin
			cur_q <= '0;
		end else if (cmd.cur_inc) begin
			cur_q <= next_x[IW-1:0];
		end
		if (cmd.res_ld) begin
			unique case (cmd.res_sel)
				ikrl_pkg::RES_FULL: begin
					res_status_q <= ikrl_pkg::ST_FULL;
					res_index_q  <= '0;
					res_rec_q    <= '0;
				end
				ikrl_pkg::RES_CLEAR: begin
					res_status_q <= ikrl_pkg::ST_OK;
					res_index_q  <= '0;
					res_rec_q    <= '0;
				end
				ikrl_pkg::RES_APPEND: begin
					res_status_q <= ikrl_pkg::ST_OK;
					res_index_q  <= cnt_x[5:0];
					res_rec_q    <= new_rec;
				end
				ikrl_pkg::RES_HIT: begin
					res_status_q <= ikrl_pkg::ST_OK;
					res_index_q  <= cur_x[5:0];
					res_rec_q    <= rd_q;
				end
				default: begin
					res_status_q <= ikrl_pkg::ST_NOT_FOUND;
					res_index_q  <= '0;
					res_rec_q    <= '0;
				end
			endcase
		end
		if (cmd.out_ld) begin
			out_status_q <= res_status_q;
			out_index_q  <= res_index_q;
			out_rec_q    <= res_rec_q;
			out_count_q  <= cnt_x[6:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.cnt_clr) begin
				count_q <= '0;
			end else if (cmd.cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.out_ld) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, out_count_q, 48'(out_rec_q[TW-1:0]),
		out_rec_q[TW +: 32], out_rec_q[RW-1 -: 32], out_index_q, out_status_q};

endmodule

`default_nettype wire

[verif/id_keyed_record_list_test.sv]
module id_keyed_record_list_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] OP_SPARE_LO = 3'd6;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;
	localparam int         SLOTS       = 64;
	localparam int         STALL_LIMIT = 4000;
	localparam int         SETTLE      = 150;

	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  index;
		logic [31:0] id;
		logic [31:0] addr;
		logic [47:0] stamp;
		logic [6:0]  count;
	} reply_t;

	class record_list_board;
		logic [31:0] ids[SLOTS];
		logic [31:0] addrs[SLOTS];
		logic [47:0] stamps[SLOTS];
		int unsigned count;
		reply_t      pending_replies[$];
		int unsigned errors;

		function void note_command(logic [2:0] op, logic [31:0] key, logic [31:0] addr,
			logic [47:0] stamp, logic [5:0] pos);
			reply_t r;
			int     at;
			r = '0;
			r.status = ikrl_pkg::ST_NOT_FOUND;
			at = -1;
			if (op == ikrl_pkg::OP_FIND || op == ikrl_pkg::OP_RM_ID) begin
				for (int k = 0; k < count; k++) begin
					if (ids[k] == key) begin
						at = k;
						break;
					end
				end
			end else if ((op == ikrl_pkg::OP_RM_IDX || op == ikrl_pkg::OP_READ) &&
				pos < count) begin
				at = int'(pos);
			end
			case (op)
				ikrl_pkg::OP_APPEND: begin
					if (count >= SLOTS) begin
						r.status = ikrl_pkg::ST_FULL;
					end else begin
						ids[count] = key;
						addrs[count] = addr;
						stamps[count] = stamp;
						r.status = ikrl_pkg::ST_OK;
						r.index = 6'(count);
						r.id = key;
						r.addr = addr;
						r.stamp = stamp;
						count++;
					end
				end
				ikrl_pkg::OP_RM_IDX, ikrl_pkg::OP_READ, ikrl_pkg::OP_FIND,
				ikrl_pkg::OP_RM_ID: begin
					if (at >= 0) begin
						r.status = ikrl_pkg::ST_OK;
						r.index = 6'(at);
						r.id = ids[at];
						r.addr = addrs[at];
						r.stamp = stamps[at];
						if (op == ikrl_pkg::OP_RM_IDX || op == ikrl_pkg::OP_RM_ID) begin
							for (int k = at; k + 1 < count; k++) begin
								ids[k] = ids[k + 1];
								addrs[k] = addrs[k + 1];
								stamps[k] = stamps[k + 1];
							end
							count--;
						end
					end
				end
				ikrl_pkg::OP_CLEAR: begin
					r.status = ikrl_pkg::ST_OK;
					count = 0;
				end
				default: ;
			endcase
			r.count = 7'(count);
			pending_replies.push_back(r);
		endfunction

		function void compare_field(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_reply(logic [127:0] beat);
			reply_t want;
			if (pending_replies.size() == 0) begin
				$error("result beat with no command outstanding: %h", beat);
				errors++;
				return;
			end
			want = pending_replies.pop_front();
			compare_field("status", 64'(want.status), 64'(beat[1:0]));
			compare_field("entry_index", 64'(want.index), 64'(beat[7:2]));
			compare_field("entry_id", 64'(want.id), 64'(beat[39:8]));
			compare_field("entry_address", 64'(want.addr), 64'(beat[71:40]));
			compare_field("entry_time", 64'(want.stamp), 64'(beat[119:72]));
			compare_field("entry_count", 64'(want.count), 64'(beat[126:120]));
		endfunction
	endclass

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [127:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [127:0] m_tdata;

	record_list_board board;
	logic [31:0]      key_base;
	logic             steady;
	int unsigned      quiet_cycles = 0;

	id_keyed_record_list i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(negedge clk) begin
		m_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 32);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			board.check_reply(m_tdata);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic send_command(logic [2:0] op, logic [31:0] key, logic [31:0] addr,
		logic [47:0] stamp, logic [5:0] pos);
		@(negedge clk);
		if (!steady) begin
			while ($urandom_range(0, 99) < 32) begin
				s_tvalid <= 1'b0;
				@(negedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, pos, stamp, addr, key, op};
		do @(posedge clk); while (!s_tready);
		board.note_command(op, key, addr, stamp, pos);
	endtask

	task automatic drain_replies();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (board.pending_replies.size() != 0) @(posedge clk);
	endtask

	task automatic random_command(int append_pct);
		logic [2:0]  op;
		logic [31:0] key;
		logic [63:0] wide;
		logic [5:0]  pos;
		int          pick;
		pick = $urandom_range(0, 99);
		if (pick < append_pct) begin
			op = ikrl_pkg::OP_APPEND;
		end else if (pick == 99) begin
			op = $urandom_range(0, 1) ? ikrl_pkg::OP_CLEAR : ikrl_pkg::OP_READ;
		end else if (pick == 98) begin
			op = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
		end else begin
			case (pick % 4)
				0: op = ikrl_pkg::OP_RM_IDX;
				1: op = ikrl_pkg::OP_READ;
				2: op = ikrl_pkg::OP_FIND;
				default: op = ikrl_pkg::OP_RM_ID;
			endcase
		end
		if ((op == ikrl_pkg::OP_FIND || op == ikrl_pkg::OP_RM_ID) && board.count != 0 &&
			$urandom_range(0, 9) < 6) begin
			key = board.ids[$urandom_range(0, board.count - 1)];
		end else if ($urandom_range(0, 3) == 0) begin
			key = $urandom;
		end else begin
			key = key_base ^ $urandom_range(0, 15);
		end
		if (board.count != 0 && $urandom_range(0, 9) < 7) begin
			pos = 6'($urandom_range(0, board.count - 1));
		end else begin
			pos = 6'($urandom_range(0, 63));
		end
		wide = {$urandom, $urandom};
		send_command(op, key, $urandom, wide[47:0], pos);
	endtask

	initial begin
		board = new();
		key_base = $urandom;
		steady = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_command(ikrl_pkg::OP_READ, 32'h0, 32'h0, 48'h0, 6'd0);
		send_command(ikrl_pkg::OP_RM_IDX, 32'h0, 32'h0, 48'h0, 6'd63);
		send_command(ikrl_pkg::OP_FIND, 32'h0, 32'h0, 48'h0, 6'd0);
		send_command(ikrl_pkg::OP_RM_ID, '1, '1, '1, '1);
		send_command(OP_SPARE_LO, '1, '1, '1, '1);
		send_command(OP_SPARE_HI, 32'h0, 32'h0, 48'h0, 6'd0);
		send_command(ikrl_pkg::OP_APPEND, '1, '1, '1, '1);
		send_command(ikrl_pkg::OP_APPEND, 32'h0, 32'h0, 48'h0, 6'd0);
		send_command(ikrl_pkg::OP_APPEND, 32'h0000_1234, 32'hA5A5_0001, 48'h0123_4567_89AB,
			6'd0);
		send_command(ikrl_pkg::OP_APPEND, 32'h0000_1234, 32'h5A5A_0002, 48'hFEDC_BA98_7654,
			6'd0);
		send_command(ikrl_pkg::OP_FIND, 32'h0000_1234, 32'h0, 48'h0, 6'd0);
		send_command(ikrl_pkg::OP_FIND, '1, 32'h0, 48'h0, 6'd0);
		send_command(ikrl_pkg::OP_READ, 32'h0, 32'h0, 48'h0, 6'd63);
		send_command(ikrl_pkg::OP_READ, 32'h0, 32'h0, 48'h0, 6'd3);
		send_command(ikrl_pkg::OP_RM_ID, 32'h0000_1234, 32'h0, 48'h0, 6'd0);
		send_command(ikrl_pkg::OP_FIND, 32'h0000_1234, 32'h0, 48'h0, 6'd0);
		send_command(ikrl_pkg::OP_RM_IDX, 32'h0, 32'h0, 48'h0, 6'd0);
		send_command(ikrl_pkg::OP_READ, 32'h0, 32'h0, 48'h0, 6'd0);
		send_command(ikrl_pkg::OP_RM_IDX, 32'h0, 32'h0, 48'h0, 6'd2);
		send_command(ikrl_pkg::OP_CLEAR, '1, '1, '1, '1);
		send_command(ikrl_pkg::OP_READ, 32'h0, 32'h0, 48'h0, 6'd0);
		send_command(ikrl_pkg::OP_APPEND, 32'hDEAD_0001, 32'h1000_0000, 48'h8000_0000_0001,
			6'd0);
		drain_replies();

		for (int round = 0; round < 5; round++) begin
			steady = (round == 2);
			repeat (150) random_command(75);
			repeat (100) random_command(20);
			if (round == 1) begin
				drain_replies();
			end
		end
		steady = 1'b0;
		drain_replies();
		repeat (SETTLE) @(posedge clk);
		if (board.errors == 0 && board.pending_replies.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
